[design/xor_checked_frame_parser_top_assert.svh]
// Assertion macros used by the frame parser controller (xcfp_ctrl).
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef XOR_CHECKED_FRAME_PARSER_TOP_ASSERT_SVH
`define XOR_CHECKED_FRAME_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define XCFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define XCFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/xcfp_pkg.sv]
// Shared types and constants of the XOR-checked frame parser.
// No dependencies; imported by the controller, the datapath and the top level.
package xcfp_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int CFG_ADDR_W  = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_FIRST   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_SECOND  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIRECTION_IN = 2'd2;

  localparam logic [7:0] SYNC_FIRST_RST   = 8'd36;
  localparam logic [7:0] SYNC_SECOND_RST  = 8'd77;
  localparam logic [7:0] DIRECTION_IN_RST = 8'd60;

  typedef enum logic [1:0] {
    FS_BYTE  = 2'd0,
    FS_EMPTY = 2'd1,
    FS_BAD   = 2'd2,
    FS_BIG   = 2'd3
  } frame_status_t;

  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_DIR,
    PH_LEN,
    PH_CMD,
    PH_DATA,
    PH_SUM,
    PH_EMIT_RD,
    PH_EMIT_WR
  } phase_t;

  // Controller to datapath.
  typedef struct packed {
    logic          load_len;
    logic          load_cmd;
    logic          store_data;
    logic          put_status;
    frame_status_t status;
    logic          rd_first;
    logic          put_byte;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic sync1_hit;
    logic sync2_hit;
    logic dir_hit;
    logic len_zero;
    logic len_big;
    logic data_done;
    logic sum_ok;
    logic emit_last;
    logic out_free;
  } dp_status_t;

endpackage

[design/xcfp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module xcfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/xcfp_ctrl.sv]
// Frame parser controller: phase state machine and command decode.
// Depends on xcfp_pkg and the shared assertion header.
`include "xor_checked_frame_parser_top_assert.svh"

module xcfp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  xcfp_pkg::dp_status_t sts,
  output xcfp_pkg::ctrl_cmd_t  cmd
);
  import xcfp_pkg::*;

  phase_t state_r;
  phase_t state_nxt;
  logic   accept;

  assign accept = in_tvalid & in_tready;

  // Result-producing phases take a byte only when the output slot is free.
  always_comb begin
    case (state_r)
      PH_CMD, PH_SUM:        in_tready = sts.out_free;
      PH_EMIT_RD, PH_EMIT_WR: in_tready = 1'b0;
      default:               in_tready = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PH_SYNC2: if (accept && sts.sync2_hit) state_nxt = PH_DIR;
      PH_DIR:   if (accept && sts.dir_hit) state_nxt = PH_LEN;
      PH_LEN:   if (accept) state_nxt = PH_CMD;
      PH_CMD: begin
        if (accept) begin
          if (sts.len_big) state_nxt = PH_SYNC1;
          else if (sts.len_zero) state_nxt = PH_SUM;
          else state_nxt = PH_DATA;
        end
      end
      PH_DATA:  if (accept && sts.data_done) state_nxt = PH_SUM;
      PH_SUM: begin
        if (accept) begin
          if (!sts.sum_ok || sts.len_zero) state_nxt = PH_SYNC1;
          else state_nxt = PH_EMIT_RD;
        end
      end
      PH_EMIT_RD: state_nxt = PH_EMIT_WR;
      PH_EMIT_WR: if (sts.out_free && sts.emit_last) state_nxt = PH_SYNC1;
      default: begin
        state_nxt = PH_SYNC1;
        if (accept && sts.sync1_hit) state_nxt = PH_SYNC2;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.status = FS_BYTE;
    case (state_r)
      PH_LEN:  cmd.load_len = accept;
      PH_CMD: begin
        cmd.load_cmd   = accept;
        cmd.put_status = accept & sts.len_big;
        cmd.status     = FS_BIG;
      end
      PH_DATA: cmd.store_data = accept;
      PH_SUM: begin
        cmd.put_status = accept & (!sts.sum_ok | sts.len_zero);
        cmd.status     = sts.sum_ok ? FS_EMPTY : FS_BAD;
        cmd.rd_first   = accept & sts.sum_ok & !sts.len_zero;
      end
      PH_EMIT_WR: cmd.put_byte = sts.out_free;
      default: cmd.load_len = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_SYNC1;
    end else begin
      state_r <= state_nxt;
    end
  end

  `XCFP_ASSERT_NOW(a_no_accept_in_emit,
    in_tready, (state_r != PH_EMIT_RD) && (state_r != PH_EMIT_WR),
    "input taken while payload is being emitted")
  `XCFP_ASSERT_NOW(a_load_needs_free,
    cmd.put_status || cmd.put_byte, sts.out_free,
    "result loaded over an unconsumed result")
  `XCFP_ASSERT_NEXT(a_read_then_write,
    state_r == PH_EMIT_RD, state_r == PH_EMIT_WR,
    "first payload read not followed by emit")
  `XCFP_ASSERT_NEXT(a_emit_start,
    cmd.rd_first, state_r == PH_EMIT_RD,
    "payload emission did not start after good checksum")

endmodule

[design/xcfp_dp.sv]
// Frame parser datapath: config registers, header, checksum, payload
// store and output register. Depends on xcfp_pkg and xcfp_ram.
module xcfp_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [xcfp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [7:0]                        cfg_wdata,
  input  logic [7:0]                        in_byte,
  input  xcfp_pkg::ctrl_cmd_t               cmd,
  output xcfp_pkg::dp_status_t              sts,
  input  logic                              out_tready,
  output logic                              out_valid,
  output xcfp_pkg::frame_status_t           out_status,
  output logic [7:0]                        out_command,
  output logic [7:0]                        out_length,
  output logic [xcfp_pkg::IDX_W-1:0]        out_index,
  output logic [7:0]                        out_payload,
  output logic                              out_last
);
  import xcfp_pkg::*;

  logic [7:0]       sync_first_r, sync_first_nxt;
  logic [7:0]       sync_second_r, sync_second_nxt;
  logic [7:0]       direction_in_r, direction_in_nxt;
  logic [7:0]       held_len_r, held_len_nxt;
  logic [7:0]       held_cmd_r, held_cmd_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  frame_status_t    out_status_r, out_status_nxt;
  logic [7:0]       out_command_r, out_command_nxt;
  logic [7:0]       out_length_r, out_length_nxt;
  logic [IDX_W-1:0] out_index_r, out_index_nxt;
  logic [7:0]       out_payload_r, out_payload_nxt;
  logic             out_last_r, out_last_nxt;
  logic [7:0]       ram_rd_data;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;

  xcfp_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk    (clk),
    .wr_en  (cmd.store_data),
    .wr_addr(count_r[IDX_W-1:0]),
    .wr_data(in_byte),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  assign ram_rd_en   = cmd.rd_first | cmd.put_byte;
  assign ram_rd_addr = cmd.rd_first ? '0 : IDX_W'(idx_r + 1'b1);

  always_comb begin
    sts.sync1_hit = (in_byte == sync_first_r);
    sts.sync2_hit = (in_byte == sync_second_r);
    sts.dir_hit   = (in_byte == direction_in_r);
    sts.len_zero  = (held_len_r == 8'd0);
    sts.len_big   = (held_len_r > 8'(MAX_PAYLOAD));
    sts.data_done = ((8'(count_r) + 8'd1) >= held_len_r);
    sts.sum_ok    = (xor_r == in_byte);
    sts.emit_last = ((8'(idx_r) + 8'd1) == held_len_r);
    sts.out_free  = !out_valid_r | out_tready;
  end

  always_comb begin
    sync_first_nxt   = sync_first_r;
    sync_second_nxt  = sync_second_r;
    direction_in_nxt = direction_in_r;
    if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_SYNC_FIRST:   sync_first_nxt   = cfg_wdata;
        CFG_SYNC_SECOND:  sync_second_nxt  = cfg_wdata;
        CFG_DIRECTION_IN: direction_in_nxt = cfg_wdata;
        default:          sync_first_nxt   = sync_first_r;
      endcase
    end
  end

  always_comb begin
    held_len_nxt = held_len_r;
    held_cmd_nxt = held_cmd_r;
    xor_nxt      = xor_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    if (cmd.load_len) begin
      held_len_nxt = in_byte;
      xor_nxt      = in_byte;
    end
    if (cmd.load_cmd) begin
      held_cmd_nxt = in_byte;
      xor_nxt      = xor_r ^ in_byte;
      count_nxt    = '0;
    end
    if (cmd.store_data) begin
      xor_nxt   = xor_r ^ in_byte;
      count_nxt = CNT_W'(count_r + 1'b1);
    end
    if (cmd.rd_first) idx_nxt = '0;
    if (cmd.put_byte) idx_nxt = IDX_W'(idx_r + 1'b1);
  end

  // Output register: load a new result, or drop the current one once taken.
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_command_nxt = out_command_r;
    out_length_nxt  = out_length_r;
    out_index_nxt   = out_index_r;
    out_payload_nxt = out_payload_r;
    out_last_nxt    = out_last_r;
    if (cmd.put_status) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = cmd.status;
      out_command_nxt = cmd.load_cmd ? in_byte : held_cmd_r;
      out_length_nxt  = held_len_r;
      out_index_nxt   = '0;
      out_payload_nxt = 8'd0;
      out_last_nxt    = 1'b1;
    end else if (cmd.put_byte) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = FS_BYTE;
      out_command_nxt = held_cmd_r;
      out_length_nxt  = held_len_r;
      out_index_nxt   = idx_r;
      out_payload_nxt = ram_rd_data;
      out_last_nxt    = sts.emit_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r   <= SYNC_FIRST_RST;
      sync_second_r  <= SYNC_SECOND_RST;
      direction_in_r <= DIRECTION_IN_RST;
      held_len_r     <= 8'd0;
      held_cmd_r     <= 8'd0;
      xor_r          <= 8'd0;
      count_r        <= '0;
      idx_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      sync_first_r   <= sync_first_nxt;
      sync_second_r  <= sync_second_nxt;
      direction_in_r <= direction_in_nxt;
      held_len_r     <= held_len_nxt;
      held_cmd_r     <= held_cmd_nxt;
      xor_r          <= xor_nxt;
      count_r        <= count_nxt;
      idx_r          <= idx_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_command_r <= out_command_nxt;
    out_length_r  <= out_length_nxt;
    out_index_r   <= out_index_nxt;
    out_payload_r <= out_payload_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_command = out_command_r;
  assign out_length  = out_length_r;
  assign out_index   = out_index_r;
  assign out_payload = out_payload_r;
  assign out_last    = out_last_r;

endmodule

[design/xor_checked_frame_parser_top.sv]
// Output: a status result (empty, checksum error, oversize) is registered in the cycle after
//   its closing byte is accepted; a good frame's first payload byte passes the store read,
//   PH_EMIT_RD and PH_EMIT_WR, then one byte per cycle while the sink keeps tready high.
// Throughput: one byte per cycle while parsing, but the command and checksum bytes wait for a
//   free output slot; input is held off while the payload store (one read port) is drained.
// Reset: rst_n synchronous, active low; parser hunts the first sync, registers back to defaults.
//
// Top level: frame parser built from the controller, the datapath and the payload store.
// Depends on xcfp_pkg, xcfp_ctrl, xcfp_dp and xcfp_ram.
module xor_checked_frame_parser_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port.
  input  logic                            cfg_wr_en,
  input  logic [xcfp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [7:0]                      cfg_wdata,
  // Received byte stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,  // [7:0] rx_byte
  // Parse results.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] command_code, [15:8] payload_length, [20:16] byte_index,
  // [28:21] payload_byte, [31:29] zero
  output logic [31:0]                     out_tdata,
  output logic [1:0]                      out_tuser, // [1:0] frame_status
  output logic                            out_tlast  // last result of the frame
);
  import xcfp_pkg::*;

  ctrl_cmd_t        cmd;
  dp_status_t       sts;
  frame_status_t    res_status;
  logic [7:0]       res_command;
  logic [7:0]       res_length;
  logic [IDX_W-1:0] res_index;
  logic [7:0]       res_payload;

  // Phase machine: decides when a byte is taken and what the datapath does with it.
  xcfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Header, checksum, payload store and the output register.
  xcfp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_byte    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_status (res_status),
    .out_command(res_command),
    .out_length (res_length),
    .out_index  (res_index),
    .out_payload(res_payload),
    .out_last   (out_tlast)
  );

  // Pack the result fields, lowest field first, zero fill to 32 bits.
  assign out_tdata = {3'b000, res_payload, res_index, res_length, res_command};
  assign out_tuser = res_status;

endmodule

[tb/testbench.sv]
// Self-checking testbench for xor_checked_frame_parser_top: drives framed byte
// streams, predicts every parse result and checks each output transaction.
// Depends on xcfp_pkg and the RTL of the frame parser; nothing else.
module testbench;
  import xcfp_pkg::*;

  // Register index past the last register; writes there must be ignored.
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  // One parse result as it leaves the block.
  typedef struct packed {
    frame_status_t status;
    logic [7:0]    command;
    logic [7:0]    length;
    logic [4:0]    index;
    logic [7:0]    value;
    logic          last;
  } parse_result_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [7:0]            cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata  = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  xor_checked_frame_parser_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #800_000;
    $display("[xor_checked_frame_parser_top] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Parser prediction: own copy of the registers, the parse state and the store.
  // ---------------------------------------------------------------------------
  logic [7:0]    cur_sync_first  = SYNC_FIRST_RST;
  logic [7:0]    cur_sync_second = SYNC_SECOND_RST;
  logic [7:0]    cur_direction   = DIRECTION_IN_RST;
  phase_t        hunt_phase      = PH_SYNC1;
  logic [7:0]    frame_command   = '0;
  logic [7:0]    frame_length    = '0;
  logic [7:0]    frame_xor       = '0;
  logic [7:0]    frame_count     = '0;
  logic [7:0]    frame_payload [MAX_PAYLOAD];

  parse_result_t expected_results [$];
  logic [7:0]    pending_bytes [$];
  int            errors = 0;

  function automatic parse_result_t make_result(frame_status_t status, logic [4:0] index,
                                                logic [7:0] value, logic last);
    parse_result_t r;
    r.status  = status;
    r.command = frame_command;
    r.length  = frame_length;
    r.index   = index;
    r.value   = value;
    r.last    = last;
    return r;
  endfunction

  // Advance the parse state by one received byte and queue what it yields.
  task automatic parse_byte(input logic [7:0] b);
    case (hunt_phase)
      PH_SYNC2: if (b == cur_sync_second) hunt_phase = PH_DIR;
      PH_DIR:   if (b == cur_direction) hunt_phase = PH_LEN;
      PH_LEN: begin
        frame_length = b;
        frame_xor    = b;
        hunt_phase   = PH_CMD;
      end
      PH_CMD: begin
        frame_command = b;
        frame_xor     = frame_xor ^ b;
        frame_count   = '0;
        if (frame_length > MAX_PAYLOAD) begin
          // Oversize: report at once, the rest of the frame is noise.
          expected_results.push_back(make_result(FS_BIG, '0, '0, 1'b1));
          hunt_phase = PH_SYNC1;
        end else if (frame_length != 0) begin
          hunt_phase = PH_DATA;
        end else begin
          hunt_phase = PH_SUM;
        end
      end
      PH_DATA: begin
        if (frame_count < MAX_PAYLOAD) frame_payload[frame_count[4:0]] = b;
        frame_xor   = frame_xor ^ b;
        frame_count = frame_count + 8'd1;
        if (frame_count >= frame_length) hunt_phase = PH_SUM;
      end
      PH_SUM: begin
        if (frame_xor != b) begin
          expected_results.push_back(make_result(FS_BAD, '0, '0, 1'b1));
        end else if (frame_length == 0) begin
          expected_results.push_back(make_result(FS_EMPTY, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i < frame_length && i < MAX_PAYLOAD; i++)
            expected_results.push_back(make_result(FS_BYTE, i[4:0], frame_payload[i],
                                                   (i + 1 == frame_length)));
        end
        hunt_phase = PH_SYNC1;
      end
      default: hunt_phase = (b == cur_sync_first) ? PH_SYNC2 : PH_SYNC1;
    endcase
  endtask

  function automatic string result_text(parse_result_t r);
    return $sformatf("status=%0d cmd=%h len=%h idx=%0d byte=%h last=%b",
                     r.status, r.command, r.length, r.index, r.value, r.last);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: check the output transaction first, then predict from the input one.
  // ---------------------------------------------------------------------------
  bit byte_taken = 1'b0;

  always @(posedge clk) begin : watch
    parse_result_t got;
    parse_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status  = frame_status_t'(out_tuser);
        got.command = out_tdata[7:0];
        got.length  = out_tdata[15:8];
        got.index   = out_tdata[20:16];
        got.value   = out_tdata[28:21];
        got.last    = out_tlast;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %s", $time,
                   result_text(got));
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected %s, actual %s", $time,
                     result_text(want), result_text(got));
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        byte_taken = 1'b1;
        parse_byte(in_tdata);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offer the pending bytes, hold an offer until it is taken, idle only
  // between transactions.
  // ---------------------------------------------------------------------------
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_left = 0;

  always @(negedge clk) begin : drive
    logic       next_valid;
    logic [7:0] next_data;
    next_valid = in_tvalid;
    next_data  = in_tdata;
    if (byte_taken) next_valid = 1'b0;
    byte_taken = 1'b0;
    if (!next_valid && rst_n && pending_bytes.size() != 0 &&
        $urandom_range(0, 99) >= idle_pct) begin
      next_valid = 1'b1;
      next_data  = pending_bytes.pop_front();
    end
    in_tvalid <= next_valid;
    in_tdata  <= next_data;
  end

  // Sink: random stalls, plus a long hold-off whenever hold_left is loaded.
  always @(negedge clk) begin : sink
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] byte_other_than(logic [7:0] v);
    logic [7:0] r;
    r = 8'($urandom);
    return (r == v) ? ~v : r;
  endfunction

  // Queue one frame; oversize frames carry only four noise bytes and a checksum byte.
  task automatic queue_frame(input logic [7:0] len, input logic [7:0] cmd, input fill_t fill,
                             input bit bad_sum, input bit junk);
    logic [7:0] sum;
    logic [7:0] b;
    int         n;
    pending_bytes.push_back(cur_sync_first);
    if (junk) pending_bytes.push_back(byte_other_than(cur_sync_second));
    pending_bytes.push_back(cur_sync_second);
    if (junk) pending_bytes.push_back(byte_other_than(cur_direction));
    pending_bytes.push_back(cur_direction);
    pending_bytes.push_back(len);
    pending_bytes.push_back(cmd);
    sum = len ^ cmd;
    n = (len > MAX_PAYLOAD) ? ((len > 4) ? 4 : len) : len;
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom);
      endcase
      pending_bytes.push_back(b);
      sum = sum ^ b;
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    pending_bytes.push_back(sum);
  endtask

  // Mostly well-formed frames with random content, some oversize, some noise.
  task automatic queue_random(input int count);
    int         pick;
    logic [7:0] len;
    while (pending_bytes.size() < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(7, MAX_PAYLOAD))
                                          : 8'($urandom_range(0, 6));
        queue_frame(len, 8'($urandom), FILL_RANDOM, $urandom_range(0, 99) < 15,
                    $urandom_range(0, 99) < 15);
      end else if (pick < 82) begin
        queue_frame(8'($urandom_range(MAX_PAYLOAD + 1, 255)), 8'($urandom), FILL_RANDOM,
                    1'b0, 1'b0);
      end else begin
        repeat ($urandom_range(1, 3)) pending_bytes.push_back(8'($urandom));
      end
    end
  endtask

  // Write one register while the block is idle; track it in the prediction.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (addr)
      CFG_SYNC_FIRST:   cur_sync_first  = value;
      CFG_SYNC_SECOND:  cur_sync_second = value;
      CFG_DIRECTION_IN: cur_direction   = value;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] dir);
    write_reg(CFG_SYNC_FIRST, s1);
    write_reg(CFG_SYNC_SECOND, s2);
    write_reg(CFG_DIRECTION_IN, dir);
  endtask

  // Wait until every byte is taken and every result has come, then let the block settle.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_idling(input int sender, input int receiver);
    @(posedge clk);
    idle_pct  = sender;
    stall_pct = receiver;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset register values, no idling.
    set_idling(0, 0);
    pending_bytes.push_back(8'h00);                            // noise while hunting
    pending_bytes.push_back(8'hFF);
    queue_frame(8'd0, 8'h00, FILL_RANDOM, 1'b0, 1'b0);         // good empty frame
    queue_frame(8'd0, 8'hFF, FILL_RANDOM, 1'b1, 1'b0);         // empty frame, bad checksum
    queue_frame(8'd1, 8'hFF, FILL_ONES, 1'b0, 1'b0);
    queue_frame(8'(MAX_PAYLOAD), 8'h00, FILL_ZERO, 1'b0, 1'b0); // fullest frame
    queue_frame(8'(MAX_PAYLOAD), 8'h5A, FILL_ONES, 1'b0, 1'b0);
    queue_frame(8'd3, 8'h81, FILL_RANDOM, 1'b1, 1'b0);         // payload, bad checksum
    queue_frame(8'(MAX_PAYLOAD + 1), 8'h11, FILL_RANDOM, 1'b0, 1'b0); // just oversize
    queue_frame(8'd255, 8'hEE, FILL_RANDOM, 1'b0, 1'b0);       // largest length
    queue_frame(8'd2, 8'h42, FILL_RANDOM, 1'b0, 1'b1);         // stray bytes before sync2 and dir
    queue_frame(8'd4, 8'h24, FILL_RANDOM, 1'b0, 1'b0);
    wait_drained();

    // Extreme values, plus a write to the unused index that must change nothing.
    write_all(8'h00, 8'hFF, 8'h00);
    write_reg(CFG_UNUSED, 8'hA5);
    set_idling(67, 0);
    queue_random(70);
    wait_drained();

    write_all(8'hFF, 8'h00, 8'hFF);
    set_idling(0, 67);
    queue_random(70);
    // Hold the sink off long enough for the block to stall its input.
    @(posedge clk);
    hold_left = 400;
    wait_drained();

    write_all(8'($urandom), 8'($urandom), 8'($urandom));
    set_idling(38, 38);
    queue_random(70);
    wait_drained();

    // All three registers equal.
    write_all(8'h00, 8'h00, 8'h00);
    set_idling(0, 0);
    queue_random(70);
    wait_drained();

    write_all(SYNC_FIRST_RST, SYNC_SECOND_RST, DIRECTION_IN_RST);
    set_idling(38, 38);
    queue_random(70);
    wait_drained();

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[xor_checked_frame_parser_top] OK");
    end else begin
      $display("[xor_checked_frame_parser_top] ERROR");
    end
    $finish;
  end

endmodule
